// ----- design/skpi_pkg.sv -----
// Shared types and constants of the sorted key position index.
// Used by the RAM-backed datapath, the controller and the top level.
`timescale 1ns / 1ps
package skpi_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned KeyW = 62;
  localparam int unsigned EntryW = KeyW + AddrW;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_MOVE = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [KeyW-1:0] item_key;
    logic [AddrW-1:0] list_position;
    logic [AddrW-1:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic key_found;
    logic [CntW-1:0] key_rank;
    logic [AddrW-1:0] found_position;
    logic [CntW-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic sweep;
    logic place;
    logic look_rd;
    logic look_cmp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic err;
    logic srch_done;
    logic look_hit;
    logic sweep_done;
  } dp_sts_t;
endpackage

// ----- design/skpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module skpi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- design/skpi_datapath.sv -----
// Datapath: item registers, binary search, renumbering sweep, result register.
// Depends on skpi_pkg and skpi_ram.
`timescale 1ns / 1ps
module skpi_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  skpi_pkg::in_item_t  in_item,
  input  skpi_pkg::dp_cmd_t   cmd,
  output skpi_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output skpi_pkg::out_item_t out_item
);
  localparam int unsigned AW = skpi_pkg::AddrW;
  localparam int unsigned CW = skpi_pkg::CntW;
  localparam int unsigned KW = skpi_pkg::KeyW;

  logic [1:0] act_r;
  logic [KW-1:0] key_r;
  logic [AW-1:0] pos_r, tgt_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, sw_k_r, rd_i_r, rank_r;
  logic rd_vld_r, found_r, lk_eq_r;
  logic [AW-1:0] lk_pos_r;
  logic out_valid_r;
  skpi_pkg::out_item_t out_r, out_nxt;

  logic [CW:0] sum;
  logic [CW-1:0] mid, sw_idx;
  logic issue, we, err;
  logic [1:0] err_code;
  logic [AW-1:0] waddr, raddr, p, p_nxt;
  logic [KW-1:0] wkey, rkey;
  logic [skpi_pkg::EntryW-1:0] rdata;
  logic [CW-1:0] pos_w, tgt_w;

  assign pos_w = {1'b0, pos_r};
  assign tgt_w = {1'b0, tgt_r};
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[CW:1];
  assign issue = cmd.sweep && (sw_k_r < cnt_r);
  assign sw_idx = (act_r == skpi_pkg::ACT_INSERT) ? (cnt_r - 7'd1 - sw_k_r) : sw_k_r;
  assign rkey = rdata[skpi_pkg::EntryW-1:AW];
  assign p = rdata[AW-1:0];

  always_comb begin
    err = 1'b0;
    err_code = skpi_pkg::ST_OK;
    unique case (act_r)
      skpi_pkg::ACT_INSERT: begin
        if (pos_w > cnt_r) begin
          err = 1'b1;
          err_code = skpi_pkg::ST_BAD_INDEX;
        end else if (cnt_r >= CW'(skpi_pkg::TableDepth)) begin
          err = 1'b1;
          err_code = skpi_pkg::ST_FULL;
        end
      end
      skpi_pkg::ACT_DELETE: begin
        if (pos_w >= cnt_r) begin
          err = 1'b1;
          err_code = skpi_pkg::ST_BAD_INDEX;
        end
      end
      skpi_pkg::ACT_MOVE: begin
        if (pos_r == tgt_r || pos_w >= cnt_r || tgt_w >= cnt_r) begin
          err = 1'b1;
          err_code = skpi_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = rd_i_r[AW-1:0];
    wkey = rkey;
    p_nxt = p;
    if (cmd.place) begin
      we = 1'b1;
      waddr = lo_r[AW-1:0];
      wkey = key_r;
      p_nxt = pos_r;
    end else if (cmd.sweep && rd_vld_r) begin
      unique case (act_r)
        skpi_pkg::ACT_INSERT: begin
          we = 1'b1;
          if (p >= pos_r) p_nxt = p + 6'd1;
          if (rd_i_r >= lo_r) waddr = AW'(rd_i_r + 7'd1);
        end
        skpi_pkg::ACT_DELETE: begin
          we = (p != pos_r);
          if (p > pos_r) p_nxt = p - 6'd1;
          if (found_r) waddr = AW'(rd_i_r - 7'd1);
        end
        default: begin
          we = 1'b1;
          if (p == pos_r) p_nxt = tgt_r;
          else if (pos_r > tgt_r) begin
            if (p >= tgt_r && p < pos_r) p_nxt = p + 6'd1;
          end else if (p > pos_r && p <= tgt_r) p_nxt = p - 6'd1;
        end
      endcase
    end
  end

  always_comb begin
    raddr = sw_idx[AW-1:0];
    if (cmd.srch_rd) raddr = mid[AW-1:0];
    else if (cmd.look_rd) raddr = lo_r[AW-1:0];
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.entry_count = cnt_r;
    if (err) out_nxt.status = err_code;
    else begin
      unique case (act_r)
        skpi_pkg::ACT_INSERT: begin
          out_nxt.key_rank = lo_r;
          out_nxt.found_position = pos_r;
          out_nxt.entry_count = cnt_r + 7'd1;
        end
        skpi_pkg::ACT_DELETE: begin
          out_nxt.key_rank = rank_r;
          out_nxt.found_position = pos_r;
          out_nxt.entry_count = cnt_r - 7'd1;
        end
        skpi_pkg::ACT_MOVE: begin
          out_nxt.key_rank = rank_r;
          out_nxt.found_position = tgt_r;
        end
        default: begin
          out_nxt.key_rank = lo_r;
          out_nxt.key_found = lk_eq_r;
          out_nxt.found_position = lk_pos_r;
          out_nxt.status = lk_eq_r ? skpi_pkg::ST_OK : skpi_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  skpi_ram #(.Width(skpi_pkg::EntryW), .Depth(skpi_pkg::TableDepth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({wkey, p_nxt}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      rd_vld_r <= issue;
      if (cmd.finish && !err) begin
        if (act_r == skpi_pkg::ACT_INSERT) cnt_r <= cnt_r + 7'd1;
        else if (act_r == skpi_pkg::ACT_DELETE) cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_item.action;
      key_r <= in_item.item_key;
      pos_r <= in_item.list_position;
      tgt_r <= in_item.target_position;
      lo_r <= '0;
      hi_r <= cnt_r;
      sw_k_r <= '0;
      found_r <= 1'b0;
      rank_r <= '0;
    end
    if (cmd.srch_upd) begin
      if (rkey < key_r) lo_r <= mid + 7'd1;
      else hi_r <= mid;
    end
    if (issue) begin
      sw_k_r <= sw_k_r + 7'd1;
      rd_i_r <= sw_idx;
    end
    if (cmd.sweep && rd_vld_r && p == pos_r && act_r != skpi_pkg::ACT_INSERT) begin
      found_r <= 1'b1;
      rank_r <= rd_i_r;
    end
    if (cmd.look_rd) begin
      lk_eq_r <= 1'b0;
      lk_pos_r <= '0;
    end
    if (cmd.look_cmp) begin
      lk_eq_r <= (rkey == key_r);
      lk_pos_r <= p;
    end
    if (cmd.finish) out_r <= out_nxt;
  end

  assign sts.action = act_r;
  assign sts.err = err;
  assign sts.srch_done = (lo_r >= hi_r);
  assign sts.look_hit = (lo_r < cnt_r);
  assign sts.sweep_done = (sw_k_r == cnt_r) && !rd_vld_r;
  assign out_valid = out_valid_r;
  assign out_item = out_r;
endmodule

// ----- design/skpi_ctrl.sv -----
// Controller state machine sequencing check, search, sweep, place, lookup and result.
// Depends on skpi_pkg.
`timescale 1ns / 1ps
module skpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  skpi_pkg::dp_sts_t sts,
  output skpi_pkg::dp_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_SWEEP = 4'd4;
  localparam logic [3:0] S_PLACE = 4'd5;
  localparam logic [3:0] S_LOOK = 4'd6;
  localparam logic [3:0] S_LCMP = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) state_nxt = S_FINISH;
        else if (sts.action == skpi_pkg::ACT_INSERT || sts.action == skpi_pkg::ACT_LOOKUP)
          state_nxt = S_SRCH;
        else state_nxt = S_SWEEP;
      end
      S_SRCH: begin
        if (!sts.srch_done) begin
          cmd.srch_rd = 1'b1;
          state_nxt = S_SCMP;
        end else if (sts.action == skpi_pkg::ACT_INSERT) state_nxt = S_SWEEP;
        else state_nxt = S_LOOK;
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt = S_SRCH;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = (sts.action == skpi_pkg::ACT_INSERT) ? S_PLACE : S_FINISH;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_LOOK: begin
        cmd.look_rd = 1'b1;
        state_nxt = sts.look_hit ? S_LCMP : S_FINISH;
      end
      S_LCMP: begin
        cmd.look_cmp = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ----- design/sorted_key_position_index.sv -----
// Top level of the sorted key position index.
// Depends on skpi_pkg, skpi_ctrl and skpi_datapath.
//
// Usage: drive in_item and raise start; the item is taken at a clock edge
// where start is high and busy is low. busy then stays high until the
// operation ends. One result per item appears on out_item for exactly one
// cycle, marked by out_valid; the receiver cannot stall it.
// Insert and lookup first run a binary search over the key-sorted table;
// each halving step is a RAM read followed by a compare, and a final check
// ends the search. Insert, delete and move then sweep all stored entries
// through the single RAM read port, one per cycle, renumbering and
// shifting. An item with a bad index, or an insert into a full table, goes
// straight from the check to the result. A new item may be taken in the
// cycle in which the previous result is shown.
// Reset clears the stored count and the controller; table contents need no
// clearing, since only entries below the count are used.
`timescale 1ns / 1ps
module sorted_key_position_index (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  skpi_pkg::in_item_t  in_item,
  output logic                out_valid,
  output skpi_pkg::out_item_t out_item
);
  skpi_pkg::dp_cmd_t cmd;
  skpi_pkg::dp_sts_t sts;

  skpi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  skpi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.entry_count <= 7'd64) else $error("count out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.key_found |-> out_item.status == skpi_pkg::ST_OK)
    else $error("found key with error status");
endmodule

// ----- tb/sv/sorted_key_position_index_tb.sv -----
// Testbench of the sorted key position index: drives insert, delete, move and
// lookup items and checks every result against an in-bench table predictor.
// Depends on skpi_pkg and the sorted_key_position_index top level.
`timescale 1ns / 1ps
module sorted_key_position_index_tb;
  import skpi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  sorted_key_position_index i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  logic [KeyW-1:0]  idx_keys [TableDepth];
  logic [AddrW-1:0] idx_pos [TableDepth];
  logic [KeyW-1:0]  list_keys [TableDepth];
  int unsigned      n_stored = 0;
  out_item_t        pending_results[$];
  int               n_errors = 0;
  int               send_gap_pct = 0;
  longint           cycle_cnt = 0;

  function automatic int unsigned rank_of(logic [KeyW-1:0] k);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_stored;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (idx_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    int unsigned p, t, rk, i;
    logic [KeyW-1:0] mv;
    r = '0;
    p = 32'(it.list_position);
    t = 32'(it.target_position);
    case (it.action)
      ACT_INSERT: begin
        if (p > n_stored) r.status = ST_BAD_INDEX;
        else if (n_stored >= TableDepth) r.status = ST_FULL;
        else begin
          for (i = 0; i < n_stored; i++) if (idx_pos[i] >= p) idx_pos[i]++;
          for (i = n_stored; i > p; i--) list_keys[i] = list_keys[i-1];
          list_keys[p] = it.item_key;
          rk = rank_of(it.item_key);
          for (i = n_stored; i > rk; i--) begin
            idx_keys[i] = idx_keys[i-1];
            idx_pos[i] = idx_pos[i-1];
          end
          idx_keys[rk] = it.item_key;
          idx_pos[rk] = AddrW'(p);
          n_stored++;
          r.key_rank = CntW'(rk);
          r.found_position = AddrW'(p);
        end
      end
      ACT_DELETE: begin
        if (p >= n_stored) r.status = ST_BAD_INDEX;
        else begin
          for (rk = 0; rk < n_stored; rk++) if (idx_pos[rk] == p) break;
          if (rk >= n_stored) r.status = ST_NOT_FOUND;
          else begin
            for (i = rk; i + 1 < n_stored; i++) begin
              idx_keys[i] = idx_keys[i+1];
              idx_pos[i] = idx_pos[i+1];
            end
            for (i = p; i + 1 < n_stored; i++) list_keys[i] = list_keys[i+1];
            n_stored--;
            for (i = 0; i < n_stored; i++) if (idx_pos[i] > p) idx_pos[i]--;
            r.key_rank = CntW'(rk);
            r.found_position = AddrW'(p);
          end
        end
      end
      ACT_MOVE: begin
        if (p == t || p >= n_stored || t >= n_stored) r.status = ST_BAD_INDEX;
        else begin
          rk = 0;
          for (i = 0; i < n_stored; i++) begin
            if (idx_pos[i] == p) begin
              idx_pos[i] = AddrW'(t);
              rk = i;
            end else if (p > t) begin
              if (idx_pos[i] >= t && idx_pos[i] < p) idx_pos[i]++;
            end else if (idx_pos[i] > p && idx_pos[i] <= t) idx_pos[i]--;
          end
          mv = list_keys[p];
          if (p > t) for (i = p; i > t; i--) list_keys[i] = list_keys[i-1];
          else for (i = p; i < t; i++) list_keys[i] = list_keys[i+1];
          list_keys[t] = mv;
          r.key_rank = CntW'(rk);
          r.found_position = AddrW'(t);
        end
      end
      default: begin
        rk = rank_of(it.item_key);
        r.key_rank = CntW'(rk);
        if (rk < n_stored && idx_keys[rk] == it.item_key) begin
          r.key_found = 1'b1;
          r.found_position = idx_pos[rk];
        end else begin
          r.status = ST_NOT_FOUND;
          if (rk < n_stored) r.found_position = idx_pos[rk];
        end
      end
    endcase
    r.entry_count = CntW'(n_stored);
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [KeyW-1:0] k,
                           int unsigned p, int unsigned t);
    in_item_t it;
    it.action = act;
    it.item_key = k;
    it.list_position = AddrW'(p);
    it.target_position = AddrW'(t);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_item(it));
    @(negedge clk);
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r !== out_item) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: st %0d/%0d fnd %0d/%0d rank %0d/%0d pos %0d/%0d cnt %0d/%0d",
                     exp_r.status, out_item.status, exp_r.key_found, out_item.key_found,
                     exp_r.key_rank, out_item.key_rank, exp_r.found_position,
                     out_item.found_position, exp_r.entry_count, out_item.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 400000) begin
      $display("sorted_key_position_index_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'({$urandom, $urandom});
  endfunction

  // keys close together so lookups and inserts hit equal keys often
  function automatic logic [KeyW-1:0] near_key();
    int unsigned j;
    if (n_stored > 0 && $urandom_range(1)) begin
      j = $urandom_range(n_stored - 1);
      return idx_keys[j] + $urandom_range(2) - 1;
    end
    return {2'($urandom_range(3)), 28'd0, 32'($urandom_range(7))};
  endfunction

  task automatic test_directed();
    send_item(ACT_LOOKUP, '0, 0, 0);
    send_item(ACT_DELETE, '0, 0, 0);
    send_item(ACT_MOVE, '0, 0, 1);
    send_item(ACT_INSERT, '0, 1, 0);
    send_item(ACT_INSERT, {KeyW{1'b1}}, 0, 0);
    send_item(ACT_INSERT, '0, 1, 0);
    send_item(ACT_INSERT, '0, 0, 0);
    send_item(ACT_INSERT, 62'h1555_5555_5555_5555, 3, 0);
    send_item(ACT_LOOKUP, '0, 0, 0);
    send_item(ACT_LOOKUP, {KeyW{1'b1}}, 0, 0);
    send_item(ACT_LOOKUP, 62'h2AAA_AAAA_AAAA_AAAA, 0, 0);
    send_item(ACT_LOOKUP, 62'h1, 0, 0);
    send_item(ACT_MOVE, '0, 0, 3);
    send_item(ACT_MOVE, '0, 3, 0);
    send_item(ACT_MOVE, '0, 2, 2);
    send_item(ACT_MOVE, '0, 4, 0);
    send_item(ACT_DELETE, '0, 4, 0);
    send_item(ACT_DELETE, '0, 63, 0);
    send_item(ACT_DELETE, '0, 1, 0);
    send_item(ACT_INSERT, 62'h5, 63, 63);
  endtask

  task automatic test_fill_full();
    while (n_stored < TableDepth)
      send_item(ACT_INSERT, near_key(), $urandom_range(n_stored), $urandom_range(63));
    send_item(ACT_INSERT, rand_key(), TableDepth - 1, 0);
    send_item(ACT_MOVE, '0, 63, 0);
    send_item(ACT_MOVE, '0, 0, 63);
    send_item(ACT_LOOKUP, {KeyW{1'b1}}, 0, 0);
    send_item(ACT_DELETE, '0, 63, 0);
    send_item(ACT_INSERT, 62'h0, 63, 0);
    while (n_stored > 0) send_item(ACT_DELETE, '0, $urandom_range(n_stored - 1), 0);
  endtask

  task automatic test_random(int n);
    int unsigned sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 10)
        send_item(2'($urandom_range(3)), rand_key(), $urandom_range(63),
                  $urandom_range(63));
      else if (sel < 45 && n_stored < 40)
        send_item(ACT_INSERT, $urandom_range(3) == 0 ? rand_key() : near_key(),
                  $urandom_range(n_stored), $urandom_range(63));
      else if (sel < 62 && n_stored > 0)
        send_item(ACT_DELETE, rand_key(), $urandom_range(n_stored - 1), $urandom_range(63));
      else if (sel < 80 && n_stored > 1)
        send_item(ACT_MOVE, rand_key(), $urandom_range(n_stored - 1),
                  $urandom_range(n_stored - 1));
      else
        send_item(ACT_LOOKUP, near_key(), $urandom_range(63), $urandom_range(63));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 16;
    test_directed();
    test_fill_full();
    test_random(250);
    send_gap_pct = 61;
    test_random(250);
    send_gap_pct = 0;
    test_random(250);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) $display("sorted_key_position_index_tb: done, clean");
    else $display("sorted_key_position_index_tb: done, errors");
    $finish;
  end
endmodule
